// ----- hdl/wmf_pkg.sv -----
// ----------------------------------------------------------------------------
// wmf_pkg: shared types and constants of the window median filter
// Sizes of the line store, the window and the configuration codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wmf_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 2;
    localparam int LINES      = 2 * MAX_RADIUS;
    localparam int WIN        = LINES + 1;
    localparam int NCELL      = WIN * WIN;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 8;
    localparam int RANK_W     = $clog2(NCELL + 1);

    // rank of the median among the active window elements
    localparam int MED_RANK_3 = 4;
    localparam int MED_RANK_5 = 12;

    typedef enum logic [1:0] {
        CFG_WINDOW_MODE  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_index_t;

    typedef logic [PIX_W-1:0]             pix_t;
    typedef logic [WIN-1:0][PIX_W-1:0]    pix_col_t;   // element 0 is the oldest line
    typedef logic [NCELL-1:0][PIX_W-1:0]  win_t;       // index line*WIN + column

    typedef struct packed {
        logic        valid;
        logic        mode;
        logic [10:0] center_x;
        logic [11:0] center_y;
    } win_tag_t;

    typedef struct packed {
        logic        valid;
        pix_t        median_grey;
        logic [10:0] center_x;
        logic [11:0] center_y;
    } med_res_t;

endpackage

`default_nettype wire

// ----- hdl/wmf_pixel_if.sv -----
// ----------------------------------------------------------------------------
// wmf_pixel_if: pixel request channel
// Valid/ready channel carrying one grey pixel and its frame start mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmf_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] grey_pixel;
    logic       frame_start;

    modport source (output valid, output grey_pixel, output frame_start, input ready);
    modport sink   (input valid, input grey_pixel, input frame_start, output ready);
endinterface

`default_nettype wire

// ----- hdl/wmf_median_if.sv -----
// ----------------------------------------------------------------------------
// wmf_median_if: median result channel
// Valid/ready channel carrying one median value and its centre position.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmf_median_if;
    logic        valid;
    logic        ready;
    logic [7:0]  median_grey;
    logic [10:0] center_x;
    logic [11:0] center_y;

    modport source (output valid, output median_grey, output center_x, output center_y,
                    input ready);
    modport sink   (input valid, input median_grey, input center_x, input center_y,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/window_median_filter.sv -----
// ----------------------------------------------------------------------------
// window_median_filter: streaming 3x3 / 5x5 median filter
// Position tracking, line store, window cell chain and median pipeline.
// ----------------------------------------------------------------------------
// Takes one grey pixel per clock in raster order and returns, for every
// pixel at least the window radius away from the top and left edges of the
// incoming data, the median of the 3x3 or 5x5 window around it with the
// centre coordinates. Throughput is one pixel per cycle when not stalled,
// set by the line store: one word per column holding all four buffered lines,
// read and written once per cycle. Pixels pass the input register, window
// cells, both rank stages and the output register; a result-side stall holds
// them all. The user must write configuration only while idle; not enforced.
`default_nettype none

module window_median_filter
    import wmf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_wdata,
    wmf_pixel_if.sink      pixel_in,
    wmf_median_if.source   median_out
);

    logic        mode_reg;
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [10:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;

    logic        en, acc;
    logic [11:0] w_eff, c0, nx;
    logic [12:0] h_eff, r0, r1, ny;
    logic [10:0] x;
    logic [11:0] y;
    logic        prod;

    logic        s1_valid_reg, s1_prod_reg, s1_mode_reg;
    pix_t        s1_pix_reg;
    logic [10:0] s1_x_reg, s1_cx_reg;
    logic [11:0] s1_cy_reg;

    win_tag_t    s2_tag_reg;
    logic [LINES*PIX_W-1:0] rd_data;
    pix_col_t    new_col;
    pix_col_t    cell_col [WIN];
    win_t        win;
    med_res_t    med_res;

    logic        out_valid_reg;
    pix_t        out_med_reg;
    logic [10:0] out_cx_reg;
    logic [11:0] out_cy_reg;

    assign en  = !out_valid_reg || median_out.ready;
    assign acc = pixel_in.valid && en;
    assign pixel_in.ready = en;

    // position of the incoming pixel, with wrap after a size change
    always_comb
    begin
        priority if (width_reg == 12'd0)
            w_eff = 12'd1;
        else if (width_reg > 12'(MAX_WIDTH))
            w_eff = 12'(MAX_WIDTH);
        else
            w_eff = width_reg;

        priority if (height_reg == 13'd0)
            h_eff = 13'd1;
        else if (height_reg > 13'(MAX_HEIGHT))
            h_eff = 13'(MAX_HEIGHT);
        else
            h_eff = height_reg;

        c0 = pixel_in.frame_start ? 12'd0 : {1'b0, col_reg};
        r0 = pixel_in.frame_start ? 13'd0 : {1'b0, row_reg};
        if (c0 >= w_eff)
        begin
            c0 = 12'd0;
            r1 = r0 + 13'd1;
        end
        else
        begin
            r1 = r0;
        end
        if (r1 >= h_eff)
        begin
            r1 = 13'd0;
        end
        x = c0[10:0];
        y = r1[11:0];

        nx = {1'b0, x} + 12'd1;
        ny = {1'b0, y} + 13'd1;
        if (nx >= w_eff)
        begin
            col_next = '0;
            row_next = (ny >= h_eff) ? 12'd0 : ny[11:0];
        end
        else
        begin
            col_next = nx[10:0];
            row_next = y;
        end

        prod = mode_reg ? ((x >= 11'd4) && (y >= 12'd4))
                        : ((x >= 11'd2) && (y >= 12'd2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            width_reg  <= 12'd640;
            height_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_MODE:  mode_reg   <= cfg_wdata[0];
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[11:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (en)
            begin
                s1_valid_reg  <= acc;
                s2_tag_reg    <= '{valid:    s1_valid_reg && s1_prod_reg,
                                   mode:     s1_mode_reg,
                                   center_x: s1_cx_reg,
                                   center_y: s1_cy_reg};
                out_valid_reg <= med_res.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pix_reg <= pixel_in.grey_pixel;
            s1_x_reg   <= x;
            s1_prod_reg <= prod;
            s1_mode_reg <= mode_reg;
            s1_cx_reg  <= mode_reg ? (x - 11'd2) : (x - 11'd1);
            s1_cy_reg  <= mode_reg ? (y - 12'd2) : (y - 12'd1);
            out_med_reg <= med_res.median_grey;
            out_cx_reg  <= med_res.center_x;
            out_cy_reg  <= med_res.center_y;
        end
    end

    assign new_col = {s1_pix_reg, rd_data};

    wmf_line_buffer u_line_buffer (
        .clk     (clk),
        .rd_en   (acc),
        .rd_addr (x),
        .wr_en   (s1_valid_reg && en),
        .wr_addr (s1_x_reg),
        .wr_data (new_col[WIN-1:1]),
        .rd_data (rd_data)
    );

    // column cells, newest on the right
    for (genvar j = 0; j < WIN; j++)
    begin : g_cell
        pix_col_t cin;
        if (j == WIN - 1)
        begin : g_last
            assign cin = new_col;
        end
        else
        begin : g_mid
            assign cin = cell_col[j+1];
        end

        wmf_col_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (s1_valid_reg && en),
            .col_in  (cin),
            .col_out (cell_col[j])
        );

        for (genvar i = 0; i < WIN; i++)
        begin : g_elem
            assign win[i*WIN + j] = cell_col[j][i];
        end
    end

    wmf_rank_median u_rank_median (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .tag_in (s2_tag_reg),
        .win_in (win),
        .res    (med_res)
    );

    assign median_out.valid       = out_valid_reg;
    assign median_out.median_grey = out_med_reg;
    assign median_out.center_x    = out_cx_reg;
    assign median_out.center_y    = out_cy_reg;

endmodule

`default_nettype wire

// ----- hdl/wmf_line_buffer.sv -----
// ----------------------------------------------------------------------------
// wmf_line_buffer: store of the previous lines
// One word per column holds all buffered lines; registered read with
// bypass of a write to the same column in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_line_buffer
    import wmf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rd_en,
    input  wire logic [ADDR_W-1:0]       rd_addr,
    input  wire logic                    wr_en,
    input  wire logic [ADDR_W-1:0]       wr_addr,
    input  wire logic [LINES*PIX_W-1:0]  wr_data,
    output logic      [LINES*PIX_W-1:0]  rd_data
);

    logic [LINES*PIX_W-1:0] mem [MAX_WIDTH];
    logic [LINES*PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/wmf_col_cell.sv -----
// ----------------------------------------------------------------------------
// wmf_col_cell: one window column
// Holds one column of the window and takes its neighbour's on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_col_cell
    import wmf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     shift,
    input  wire pix_col_t col_in,
    output pix_col_t      col_out
);

    pix_col_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

// ----- hdl/wmf_rank_median.sv -----
// ----------------------------------------------------------------------------
// wmf_rank_median: pipelined rank selection
// Compares all window pairs, counts each element's rank and picks the
// element whose rank is the middle one. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_rank_median
    import wmf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire win_tag_t tag_in,
    input  wire win_t     win_in,
    output med_res_t      res
);

    win_tag_t                     tag_a_reg, tag_b_reg;
    win_t                         val_a_reg, val_b_reg;
    logic [NCELL-1:0][NCELL-1:0]  beat_a_reg;
    logic [NCELL-1:0]             act_a_reg;
    logic [NCELL-1:0]             sel_b_reg;

    logic [NCELL-1:0][NCELL-1:0]  beat_next;
    logic [NCELL-1:0]             act_next;
    logic [NCELL-1:0]             sel_next;
    logic [RANK_W-1:0]            rank_target;
    pix_t                         med_mux;

    // 3x3 uses the newest three lines and columns only
    always_comb
    begin
        for (int i = 0; i < NCELL; i++)
        begin
            act_next[i] = tag_in.mode ||
                          (((i / WIN) >= (WIN - 3)) && ((i % WIN) >= (WIN - 3)));
        end
    end

    // element j beats element i when smaller, ties broken by index
    always_comb
    begin
        for (int i = 0; i < NCELL; i++)
        begin
            for (int j = 0; j < NCELL; j++)
            begin
                beat_next[i][j] = act_next[j] && (j != i) &&
                    ((win_in[j] < win_in[i]) || ((win_in[j] == win_in[i]) && (j < i)));
            end
        end
    end

    always_comb
    begin
        rank_target = tag_a_reg.mode ? RANK_W'(MED_RANK_5) : RANK_W'(MED_RANK_3);
        for (int i = 0; i < NCELL; i++)
        begin
            sel_next[i] = act_a_reg[i] && ($countones(beat_a_reg[i]) == int'(rank_target));
        end
    end

    always_comb
    begin
        med_mux = '0;
        for (int i = 0; i < NCELL; i++)
        begin
            med_mux = med_mux | (val_b_reg[i] & {PIX_W{sel_b_reg[i]}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else if (en)
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_a_reg          <= win_in;
            beat_a_reg         <= beat_next;
            act_a_reg          <= act_next;
            val_b_reg          <= val_a_reg;
            sel_b_reg          <= sel_next;
        end
    end

    assign res.valid       = tag_b_reg.valid;
    assign res.median_grey = med_mux;
    assign res.center_x    = tag_b_reg.center_x;
    assign res.center_y    = tag_b_reg.center_y;

endmodule

`default_nettype wire

// ----- hdl/wmf_checker.sv -----
// ----------------------------------------------------------------------------
// wmf_checker: port checks of the window median filter
// Handshake and border checks on the top level's ports, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  median_grey,
    input wire logic [10:0] center_x,
    input wire logic [11:0] center_y
);

    // a stalled result keeps its request
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(median_grey) && $stable(center_x)
                                    && $stable(center_y))
        else $error("result payload changed while stalled");

    // the input side stalls only behind a waiting result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    // no result has its centre in column 0 or row 0
    a_border: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (center_x != 11'd0) && (center_y != 12'd0))
        else $error("result for a border pixel");

endmodule

bind window_median_filter wmf_checker u_wmf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (pixel_in.ready),
    .out_valid    (median_out.valid),
    .out_ready    (median_out.ready),
    .median_grey  (median_out.median_grey),
    .center_x     (median_out.center_x),
    .center_y     (median_out.center_y)
);

`default_nettype wire
